>>> rtl/core/hds_pkg.sv
// Shared constants and types for the histogram distance scorer.
package hds_pkg;

  localparam int BIN_BITS_DEF = 16;
  localparam int LOG_TABLE_BITS_DEF = 8;
  localparam int BIN_W = 16;
  localparam int SCORE_W = 48;
  localparam int METRIC_W = 2;
  localparam int QDEPTH = 2;
  localparam logic [15:0] LN2_Q16 = 16'd45426;

  typedef enum logic [1:0] {
    MET_INTERSECT = 2'd0,
    MET_LOGLIK    = 2'd1,
    MET_CHISQ     = 2'd2,
    MET_KL        = 2'd3
  } metric_t;

  // One front-to-back queue entry: classified bin pair.
  typedef struct packed {
    logic [BIN_W-1:0] m;
    logic [BIN_W-1:0] s;
    metric_t          metric;
    logic             last;
  } job_t;

endpackage

>>> rtl/core/histogram_distance_scorer.sv
// Top level of the histogram distance scorer.
// channel | handshake        | payload
// in      | push / full      | model_bin, sample_bin, last_bin
// out     | empty / pop      | score, saturated
// cfg     | cfg_valid/ready  | cfg_data (metric)
// Back part work per pair: intersection takes the minimum directly; log-likelihood one log (skipped if
// model is 0); Kullback-Leibler two logs (skipped if either bin is 0); chi-squared a 48-step divider
// (skipped if both bins are 0). The back part's term sequencer sets the rate; the front queue holds 2 pairs.
// Reset clears accumulator, saturation flag and metric to intersection.
// A full result register stalls the back part until popped.
module histogram_distance_scorer #(
  parameter int BIN_BITS = hds_pkg::BIN_BITS_DEF,
  parameter int LOG_TABLE_BITS = hds_pkg::LOG_TABLE_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  logic [hds_pkg::BIN_W-1:0] model_bin,
  input  logic [hds_pkg::BIN_W-1:0] sample_bin,
  input  logic last_bin,
  output logic empty,
  input  logic pop,
  output logic signed [hds_pkg::SCORE_W-1:0] score,
  output logic saturated,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [hds_pkg::METRIC_W-1:0] cfg_data
);
  hds_pkg::metric_t metric;
  logic job_valid, job_take;
  hds_pkg::job_t job;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) metric <= hds_pkg::MET_INTERSECT;
    else if (cfg_valid) metric <= hds_pkg::metric_t'(cfg_data);
  end

  hds_front #(.BIN_BITS(BIN_BITS)) u_front (
    .clk, .rst, .push, .full, .model_bin, .sample_bin, .last_bin,
    .metric, .job_valid, .job, .job_take
  );

  hds_back #(.BIN_BITS(BIN_BITS), .LOG_TABLE_BITS(LOG_TABLE_BITS)) u_back (
    .clk, .rst, .job_valid, .job, .job_take, .empty, .pop, .score, .saturated
  );
endmodule

>>> rtl/core/hds_front.sv
// Front part: accepts bin pairs, tags them with the metric and queues them.
module hds_front #(
  parameter int BIN_BITS = hds_pkg::BIN_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  output logic                   full,
  input  logic [hds_pkg::BIN_W-1:0] model_bin,
  input  logic [hds_pkg::BIN_W-1:0] sample_bin,
  input  logic                   last_bin,
  input  hds_pkg::metric_t       metric,
  output logic                   job_valid,
  output hds_pkg::job_t          job,
  input  logic                   job_take
);
  localparam int D = hds_pkg::QDEPTH;
  localparam int PW = $clog2(D);

  hds_pkg::job_t q [D];
  logic [PW-1:0] wp, rp;
  logic [PW:0] cnt;
  logic wr, rd;
  logic [hds_pkg::BIN_W-1:0] mmask, smask;

  assign full = (cnt == (PW+1)'(D));
  assign job_valid = (cnt != '0);
  assign wr = push && !full;
  assign rd = job_take && job_valid;
  assign job = q[rp];

  always_comb begin
    mmask = model_bin;
    smask = sample_bin;
    if (BIN_BITS < hds_pkg::BIN_W) begin
      mmask = model_bin & hds_pkg::BIN_W'((1 << BIN_BITS) - 1);
      smask = sample_bin & hds_pkg::BIN_W'((1 << BIN_BITS) - 1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      q[wp] <= '{m: mmask, s: smask, metric: metric, last: last_bin};
    end
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (wr) wp <= (wp == PW'(D-1)) ? '0 : wp + 1'b1;
      if (rd) rp <= (rp == PW'(D-1)) ? '0 : rp + 1'b1;
      cnt <= cnt + (PW+1)'(wr) - (PW+1)'(rd);
    end
  end
endmodule

>>> rtl/core/hds_back.sv
// Back part: sequenced term unit (log, divide) and saturating accumulator.
module hds_back #(
  parameter int BIN_BITS = hds_pkg::BIN_BITS_DEF,
  parameter int LOG_TABLE_BITS = hds_pkg::LOG_TABLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   job_valid,
  input  hds_pkg::job_t          job,
  output logic                   job_take,
  output logic                   empty,
  input  logic                   pop,
  output logic signed [hds_pkg::SCORE_W-1:0] score,
  output logic                   saturated
);
  localparam int BW = hds_pkg::BIN_W;
  localparam int SW = hds_pkg::SCORE_W;
  localparam int LW = 24;                 // nl fits BW+LOG_TABLE_BITS
  localparam int LQW = LW + 16;           // ln in Q.16 before trim
  localparam int NW = 2 * BW + 16;        // chi numerator width
  localparam int DW = BW + 1;             // chi denominator width
  localparam int CW = $clog2(NW + 1);
  localparam logic signed [SW+1:0] T_MAX = {3'b000, {(SW-1){1'b1}}};
  localparam logic signed [SW+1:0] T_MIN = {3'b111, {(SW-1){1'b0}}};

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_LOGA  = 9'b000000010,
    S_SQA   = 9'b000000100,
    S_LNA   = 9'b000001000,
    S_LOGB  = 9'b000010000,
    S_SQB   = 9'b000100000,
    S_LNB   = 9'b001000000,
    S_DIV   = 9'b010000000,
    S_ACC   = 9'b100000000
  } state_t;

  state_t state;
  hds_pkg::job_t cur;
  logic [31:0] y;
  logic [LOG_TABLE_BITS-1:0] f;
  logic [$clog2(LOG_TABLE_BITS+1)-1:0] it;
  logic [5:0] p;
  logic [LW-1:0] nl;
  logic [31:0] lm, ls;          // ln magnitudes in Q.16
  logic [NW-1:0] num;
  logic [DW-1:0] den;
  logic [NW:0] rem;
  logic [NW-1:0] quo;
  logic [CW-1:0] dcnt;
  logic signed [SW:0] term;
  logic signed [SW-1:0] acc;
  logic clip;
  logic out_full;

  // leading-one position
  logic [5:0] lead;
  logic [BW-1:0] lx;
  always_comb begin
    lead = '0;
    for (int i = 0; i < BW; i++) begin
      if (lx[i]) lead = 6'(i);
    end
  end

  logic [63:0] ysq;
  assign ysq = 64'(y) * 64'(y);
  logic [31:0] ynext;
  assign ynext = 32'(ysq >> 30);

  logic [LQW-1:0] lnq;
  assign lnq = LQW'((LQW'(nl) * LQW'(hds_pkg::LN2_Q16)) >> LOG_TABLE_BITS);

  logic [BW-1:0] dabs;
  assign dabs = (job.s > job.m) ? job.s - job.m : job.m - job.s;

  // restoring divider step
  logic [NW:0] rsh;
  assign rsh = {rem[NW-1:0], num[NW-1]};
  logic dsub;
  assign dsub = rsh >= (NW+1)'(den);
  logic [NW-1:0] qnext;
  assign qnext = {quo[NW-2:0], dsub};

  // product for log-likelihood / KL
  logic [31:0] ldiff;
  logic ldneg;
  logic [BW-1:0] pmul;
  logic [BW+32-1:0] prod;
  always_comb begin
    ldneg = ls < lm;
    ldiff = ldneg ? lm - ls : ls - lm;
    pmul = (cur.metric == hds_pkg::MET_LOGLIK) ? cur.s : cur.m;
    prod = (BW+32)'(pmul) * (BW+32)'(
      (cur.metric == hds_pkg::MET_LOGLIK) ? lm : ldiff);
  end

  logic signed [SW+1:0] sum;
  assign sum = (SW+2)'(acc) + (SW+2)'(term);

  assign lx = (state == S_IDLE) ? job.m : cur.s;
  assign job_take = (state == S_IDLE) && job_valid && !out_full;
  assign empty = !out_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      acc <= '0;
      clip <= 1'b0;
      out_full <= 1'b0;
    end else begin
      if (pop && out_full && !(state == S_ACC && cur.last)) out_full <= 1'b0;
      case (state)
        S_IDLE: begin
          if (job_take) begin
            cur <= job;
            lm <= '0;
            ls <= '0;
            case (job.metric)
              hds_pkg::MET_INTERSECT: begin
                if (BIN_BITS >= 16)
                  term <= (SW+1)'(((job.m < job.s) ? job.m : job.s) >> (BIN_BITS - 16));
                else
                  term <= (SW+1)'(((job.m < job.s) ? job.m : job.s)) << (16 - BIN_BITS);
                state <= S_ACC;
              end
              hds_pkg::MET_CHISQ: begin
                den <= DW'(job.s) + DW'(job.m);
                if (BIN_BITS >= 16)
                  num <= NW'(32'(dabs) * 32'(dabs));
                else
                  num <= NW'(32'(dabs) * 32'(dabs)) << (16 - BIN_BITS);
                rem <= '0;
                quo <= '0;
                dcnt <= CW'(NW);
                if (job.s == '0 && job.m == '0) begin
                  term <= '0;
                  state <= S_ACC;
                end else begin
                  state <= S_DIV;
                end
              end
              default: begin
                if (job.m == '0 || (job.metric == hds_pkg::MET_KL && job.s == '0)) begin
                  term <= '0;
                  state <= S_ACC;
                end else begin
                  p <= lead;
                  y <= 32'(64'(job.m) << (30 - lead));
                  f <= '0;
                  it <= '0;
                  state <= S_SQA;
                end
              end
            endcase
          end
        end
        S_SQA, S_SQB: begin
          it <= it + 1'b1;
          if (ynext >= 32'h8000_0000) begin
            y <= ynext >> 1;
            f <= {f[LOG_TABLE_BITS-2:0], 1'b1};
          end else begin
            y <= ynext;
            f <= {f[LOG_TABLE_BITS-2:0], 1'b0};
          end
          if (it == ($bits(it))'(LOG_TABLE_BITS - 1)) begin
            state <= (state == S_SQA) ? S_LOGA : S_LOGB;
          end
        end
        S_LOGA, S_LOGB: begin
          nl <= (LW'(BIN_BITS - 32'(p)) << LOG_TABLE_BITS) - LW'(f);
          state <= (state == S_LOGA) ? S_LNA : S_LNB;
        end
        S_LNA: begin
          lm <= 32'(lnq);
          if (cur.metric == hds_pkg::MET_KL) begin
            p <= lead;
            y <= 32'(64'(cur.s) << (30 - lead));
            f <= '0;
            it <= '0;
            state <= S_SQB;
          end else begin
            state <= S_DIV;
          end
        end
        S_LNB: begin
          ls <= 32'(lnq);
          state <= S_DIV;
        end
        S_DIV: begin
          // chi: one quotient bit per cycle; log metrics: form product term
          if (cur.metric == hds_pkg::MET_CHISQ) begin
            num <= {num[NW-2:0], 1'b0};
            rem <= dsub ? rsh - (NW+1)'(den) : rsh;
            quo <= qnext;
            dcnt <= dcnt - 1'b1;
            if (dcnt == CW'(1)) begin
              term <= (SW+1)'(qnext >> (BIN_BITS >= 16 ? BIN_BITS - 16 : 0));
              state <= S_ACC;
            end
          end else begin
            if (ldneg && cur.metric == hds_pkg::MET_KL)
              term <= -(SW+1)'(prod >> BIN_BITS);
            else
              term <= (SW+1)'(prod >> BIN_BITS);
            state <= S_ACC;
          end
        end
        S_ACC: begin
          logic signed [SW+1:0] t;
          logic signed [SW-1:0] a;
          logic c;
          t = sum;
          c = clip;
          if (t > T_MAX) begin
            a = {1'b0, {(SW-1){1'b1}}};
            c = 1'b1;
          end else if (t < T_MIN) begin
            a = {1'b1, {(SW-1){1'b0}}};
            c = 1'b1;
          end else begin
            a = SW'(t);
          end
          if (cur.last) begin
            score <= a;
            saturated <= c;
            out_full <= 1'b1;
            acc <= '0;
            clip <= 1'b0;
          end else begin
            acc <= a;
            clip <= c;
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

>>> rtl/core/hds_checker.sv
// Port-level checker for the histogram distance scorer, bound to the top.
module hds_checker (
  input logic clk,
  input logic rst,
  input logic push,
  input logic full,
  input logic empty,
  input logic pop,
  input logic signed [47:0] score,
  input logic saturated
);
  a_rst_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");
  a_rst_notfull: assert property (@(posedge clk) rst |=> !full)
    else $error("input full after reset");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(score) && $stable(saturated)))
    else $error("waiting result changed");
  a_pop_frees: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop) |=> empty)
    else $error("result reappeared without new work");
endmodule

bind histogram_distance_scorer hds_checker u_hds_checker (
  .clk, .rst, .push, .full, .empty, .pop, .score, .saturated
);

>>> tb/testbench.sv
// Self-checking testbench for the histogram distance scorer: queue driver, monitor, predictor.
module testbench;

  localparam int PERIOD = 8;
  localparam int SETTLE = 250;        // cycles of quiet before a metric write or drain
  localparam longint ACC_MAX = 64'sd140737488355327;
  localparam longint ACC_MIN = -ACC_MAX - 1;

  typedef enum logic [1:0] {W_BIN, W_METRIC, W_DRAIN} work_kind_t;

  typedef struct {
    work_kind_t        kind;
    logic [15:0]       m;
    logic [15:0]       s;
    logic              last;
    hds_pkg::metric_t  met;
    logic              calm;
  } work_t;

  typedef struct {
    logic [hds_pkg::SCORE_W-1:0] score;
    logic                        sat;
  } score_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic [hds_pkg::BIN_W-1:0] model_bin = '0;
  logic [hds_pkg::BIN_W-1:0] sample_bin = '0;
  logic last_bin = 1'b0;
  logic empty;
  logic pop = 1'b0;
  logic signed [hds_pkg::SCORE_W-1:0] score;
  logic saturated;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [hds_pkg::METRIC_W-1:0] cfg_data = '0;

  work_t  work_q[$];
  score_t score_q[$];
  longint run_sum;
  bit     clip;
  hds_pkg::metric_t cur_metric;
  int     mismatches = 0;
  int     quiet = 0;
  int     send_gap = 0;
  int     pop_gap = 0;
  bit     calm = 1'b0;
  bit     stim_done = 1'b0;

  histogram_distance_scorer u_dut (
    .clk(clk), .rst(rst),
    .push(push), .full(full),
    .model_bin(model_bin), .sample_bin(sample_bin), .last_bin(last_bin),
    .empty(empty), .pop(pop),
    .score(score), .saturated(saturated),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #(PERIOD / 2) clk = ~clk;

  // |ln(x / 2^16)| in Q.16 via bit-serial log2, 8 fraction bits
  function automatic longint unsigned neg_ln(longint unsigned x);
    int p;
    longint unsigned y;
    longint unsigned f;
    longint unsigned nl;
    p = 0;
    f = 0;
    while (p < 62 && (x >> (p + 1)) != 0) p++;
    y = (p <= 30) ? (x << (30 - p)) : (x >> (p - 30));
    for (int i = 0; i < 8; i++) begin
      y = (y * y) >> 30;
      f = f << 1;
      if (y >= (64'd2 << 30)) begin
        y = y >> 1;
        f = f | 1;
      end
    end
    nl = (longint'(16 - p) << 8) - f;
    return (nl * 45426) >> 8;
  endfunction

  function automatic longint bin_score(hds_pkg::metric_t met, longint unsigned m,
                                       longint unsigned s);
    longint unsigned d;
    longint unsigned lm;
    longint unsigned ls;
    case (met)
      hds_pkg::MET_INTERSECT: return (m < s) ? m : s;
      hds_pkg::MET_LOGLIK: begin
        if (m == 0) return 0;
        return (s * neg_ln(m)) >> 16;
      end
      hds_pkg::MET_CHISQ: begin
        if (m + s == 0) return 0;
        d = (s > m) ? s - m : m - s;
        return (d * d) / (m + s);
      end
      default: begin
        if (m == 0 || s == 0) return 0;
        lm = neg_ln(m);
        ls = neg_ln(s);
        if (ls >= lm) return (m * (ls - lm)) >> 16;
        return -longint'((m * (lm - ls)) >> 16);
      end
    endcase
  endfunction

  task automatic accumulate(logic [15:0] m, logic [15:0] s, logic last);
    longint acc;
    score_t r;
    acc = run_sum + bin_score(cur_metric, m, s);
    if (acc > ACC_MAX) begin
      acc = ACC_MAX;
      clip = 1'b1;
    end else if (acc < ACC_MIN) begin
      acc = ACC_MIN;
      clip = 1'b1;
    end
    run_sum = acc;
    if (last) begin
      r.score = acc[hds_pkg::SCORE_W-1:0];
      r.sat = clip;
      score_q.push_back(r);
      run_sum = 0;
      clip = 1'b0;
    end
  endtask

  // driver
  always @(posedge clk) begin
    bit nxt_push;
    bit nxt_cfg;
    work_t w;
    if (rst) begin
      push <= 1'b0;
      cfg_valid <= 1'b0;
      run_sum = 0;
      clip = 1'b0;
      cur_metric = hds_pkg::MET_INTERSECT;
      quiet = 0;
    end else begin
      nxt_push = push;
      nxt_cfg = cfg_valid;
      if (push && !full) begin
        accumulate(model_bin, sample_bin, last_bin);
        nxt_push = 1'b0;
        if (!calm && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 13);
      end
      if (cfg_valid && cfg_ready) begin
        cur_metric = hds_pkg::metric_t'(cfg_data);
        nxt_cfg = 1'b0;
      end
      quiet = (score_q.size() == 0 && !nxt_push) ? quiet + 1 : 0;
      if (!nxt_push && !nxt_cfg) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (work_q.size() > 0) begin
          w = work_q[0];
          case (w.kind)
            W_BIN: begin
              model_bin <= w.m;
              sample_bin <= w.s;
              last_bin <= w.last;
              calm = w.calm;
              nxt_push = 1'b1;
              void'(work_q.pop_front());
            end
            W_METRIC: begin
              if (quiet >= SETTLE) begin
                cfg_data <= w.met;
                nxt_cfg = 1'b1;
                void'(work_q.pop_front());
              end
            end
            default: begin
              if (quiet >= SETTLE) void'(work_q.pop_front());
            end
          endcase
        end
      end
      push <= nxt_push;
      cfg_valid <= nxt_cfg;
    end
  end

  // monitor
  always @(posedge clk) begin
    score_t e;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (score_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected transaction: score=%0d sat=%0b",
                                         score, saturated);
        end else begin
          e = score_q.pop_front();
          if (score !== e.score || saturated !== e.sat) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: score exp %0d got %0d, sat exp %0b got %0b",
                       $signed(e.score), score, e.sat, saturated);
          end
        end
      end
      if (calm) begin
        pop <= 1'b1;
      end else if (pop_gap > 0) begin
        pop_gap--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
        if ($urandom_range(0, 7) == 0) pop_gap = $urandom_range(1, 13);
      end
    end
  end

  function automatic logic [15:0] pick_bin();
    case ($urandom_range(0, 7))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'd1 << $urandom_range(0, 15);
      3: return 16'($urandom_range(1, 15));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic add_bin(logic [15:0] m, logic [15:0] s, logic last, logic quiet_run);
    work_t w;
    w.kind = W_BIN;
    w.m = m;
    w.s = s;
    w.last = last;
    w.met = hds_pkg::MET_INTERSECT;
    w.calm = quiet_run;
    work_q.push_back(w);
  endtask

  task automatic add_ctl(work_kind_t kind, hds_pkg::metric_t met);
    work_t w;
    w.kind = kind;
    w.m = '0;
    w.s = '0;
    w.last = 1'b0;
    w.met = met;
    w.calm = 1'b0;
    work_q.push_back(w);
  endtask

  initial begin
    int n;
    int len;
    bit drained;
    hds_pkg::metric_t met;
    drained = 1'b0;
    for (int k = 0; k < 4; k++) begin
      add_ctl(W_METRIC, hds_pkg::metric_t'(k));
      add_bin(16'd0, 16'd0, 1'b0, 1'b0);
      add_bin(16'hFFFF, 16'd0, 1'b0, 1'b0);
      add_bin(16'd0, 16'hFFFF, 1'b0, 1'b0);
      add_bin(16'hFFFF, 16'hFFFF, 1'b0, 1'b0);
      add_bin(16'd1, 16'd1, 1'b1, 1'b0);
      add_bin(16'd1, 16'hFFFF, 1'b1, 1'b0);
    end
    n = 0;
    while (n < 1700) begin
      met = hds_pkg::metric_t'($urandom_range(0, 3));
      // no metric writes in the gap-free tail
      if (n <= 1450) add_ctl(W_METRIC, met);
      for (int h = $urandom_range(1, 8); h > 0; h--) begin
        len = $urandom_range(1, 12);
        for (int i = 0; i < len; i++) begin
          // occasionally leave a histogram open across a metric change
          add_bin(pick_bin(), pick_bin(), i == len - 1 && !(h == 1 && $urandom_range(0, 5) == 0),
                  n > 1450);
          n++;
        end
      end
      if (n > 700 && !drained) begin
        add_ctl(W_DRAIN, hds_pkg::MET_INTERSECT);
        drained = 1'b1;
      end
    end
    add_bin(pick_bin(), pick_bin(), 1'b1, 1'b1);
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    wait (work_q.size() == 0 && !push && !cfg_valid && score_q.size() == 0);
    repeat (300) @(posedge clk);
    if (mismatches == 0 && score_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #(PERIOD * 6000000);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
